FILE: hw/rtl/pcnms_pkg.sv
package pcnms_pkg;

  // Width of one coordinate or score field
  localparam int unsigned FieldW = 16;
  // Width of the class field at the ports
  localparam int unsigned PortClassW = 7;
  // Reset value of the IoU threshold (about 0.45 in Q0.16)
  localparam logic [FieldW-1:0] IouThrReset = 16'd29491;

  typedef struct packed {
    logic [FieldW-1:0]     x_left;
    logic [FieldW-1:0]     y_top;
    logic [FieldW-1:0]     x_right;
    logic [FieldW-1:0]     y_bottom;
    logic [FieldW-1:0]     score;
    logic [PortClassW-1:0] class_id;
    logic                  last_box;
  } box_in_t;

  typedef struct packed {
    logic [FieldW-1:0]     kept_x_left;
    logic [FieldW-1:0]     kept_y_top;
    logic [FieldW-1:0]     kept_x_right;
    logic [FieldW-1:0]     kept_y_bottom;
    logic [FieldW-1:0]     kept_score;
    logic [PortClassW-1:0] kept_class;
    logic                  overflow;
    logic                  last_kept;
  } box_out_t;

endpackage

FILE: hw/rtl/pcnms_if.sv
// Candidate box channel
interface pcnms_box_if;
  logic              valid;
  logic              ready;
  pcnms_pkg::box_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Kept box channel
interface pcnms_kept_if;
  logic               valid;
  logic               ready;
  pcnms_pkg::box_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/per_class_greedy_nms_top.sv
// Greedy per-class NMS. Boxes are taken one per cycle into a box store of MAX_BOXES
// entries; extra boxes are dropped and flagged. The box with last_box set closes the
// set, and no further box is taken until the final kept box of the set has been placed
// in the output register. Each kept box costs one selection pass over the N stored
// boxes (one store read a cycle) and one suppression pass through the IoU pipeline,
// and is then handed to the output register.
module per_class_greedy_nms_top #(
  parameter int unsigned MAX_BOXES  = 64,
  parameter int unsigned CLASS_BITS = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pcnms_pkg::FieldW-1:0]   cfg_wdata_i,
  pcnms_box_if.sink                      in_box,
  pcnms_kept_if.source                   out_kept
);
  import pcnms_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_BOXES);
  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);
  localparam int unsigned CorW = 4 * FieldW;
  localparam int unsigned ScW  = FieldW + CLASS_BITS;

  typedef enum logic [1:0] {
    StLoad,
    StSel,
    StSup,
    StEmit
  } state_e;

  state_e            state_q;
  logic [FieldW-1:0] thr_q;
  logic [CntW-1:0]   cnt_q;
  logic              ovf_q;
  logic [CntW-1:0]   scan_q;
  logic [MAX_BOXES-1:0] done_q;
  logic              any_left_q;

  // Kept box under work
  logic              found_q;
  logic [IdxW-1:0]   best_idx_q;
  logic [FieldW-1:0] best_sc_q;
  logic [CLASS_BITS-1:0] best_cls_q;
  logic [CorW-1:0]   best_cor_q;

  // Store interface
  logic              wr_en;
  logic [CorW-1:0]   cor_wdata, cor_rdata;
  logic [ScW-1:0]    sc_wdata, sc_rdata;
  logic              issue;

  // IoU pipeline
  logic              s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic [IdxW-1:0]   s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q, s5_idx_q;
  logic              s2_c_q, s3_c_q, s4_c_q, s5_c_q;
  logic [FieldW-1:0] s2_iw_q, s2_ih_q;
  logic signed [FieldW:0] s2_wa_q, s2_ha_q, s2_wb_q, s2_hb_q;
  logic [2*FieldW-1:0] s3_inter_q, s4_inter_q, s5_inter_q;
  logic signed [2*FieldW+1:0] s3_aa_q, s3_ab_q;
  logic signed [2*FieldW+2:0] s4_uni_q;
  logic signed [3*FieldW+3:0] s5_prod_q;
  logic              s5_pos_q;

  // Stage one combinational values
  logic [FieldW-1:0] a_xl, a_yt, a_xr, a_yb, b_xl, b_yt, b_xr, b_yb;
  logic [FieldW-1:0] mx_l, mx_t, mn_r, mn_d;
  logic signed [FieldW:0] ov_w, ov_h;
  logic [FieldW-1:0] rd_sc;
  logic [CLASS_BITS-1:0] rd_cls;
  logic              s1_cand;
  logic              s5_sup;
  logic              pipe_busy;
  logic              scan_end;
  logic              emit_go;
  box_out_t          out_q;
  logic              ov_q;

  assign in_box.ready = (state_q == StLoad);
  assign wr_en        = in_box.valid && in_box.ready && (cnt_q < CntW'(MAX_BOXES));
  assign cor_wdata    = {in_box.data.y_bottom, in_box.data.x_right,
                         in_box.data.y_top, in_box.data.x_left};
  assign sc_wdata     = {in_box.data.score, CLASS_BITS'(in_box.data.class_id)};
  assign issue        = (state_q == StSel || state_q == StSup) && (scan_q < cnt_q);

  pcnms_ram #(.WIDTH(CorW), .DEPTH(MAX_BOXES)) u_cor_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i(cor_wdata),
    .raddr_i(scan_q[IdxW-1:0]),
    .rdata_o(cor_rdata)
  );

  pcnms_ram #(.WIDTH(ScW), .DEPTH(MAX_BOXES)) u_sc_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i(sc_wdata),
    .raddr_i(scan_q[IdxW-1:0]),
    .rdata_o(sc_rdata)
  );

  // Overlap geometry of the kept box against the box read this cycle
  always_comb begin
    a_xl   = best_cor_q[FieldW-1:0];
    a_yt   = best_cor_q[2*FieldW-1:FieldW];
    a_xr   = best_cor_q[3*FieldW-1:2*FieldW];
    a_yb   = best_cor_q[4*FieldW-1:3*FieldW];
    b_xl   = cor_rdata[FieldW-1:0];
    b_yt   = cor_rdata[2*FieldW-1:FieldW];
    b_xr   = cor_rdata[3*FieldW-1:2*FieldW];
    b_yb   = cor_rdata[4*FieldW-1:3*FieldW];
    mx_l   = (a_xl > b_xl) ? a_xl : b_xl;
    mx_t   = (a_yt > b_yt) ? a_yt : b_yt;
    mn_r   = (a_xr < b_xr) ? a_xr : b_xr;
    mn_d   = (a_yb < b_yb) ? a_yb : b_yb;
    ov_w   = $signed({1'b0, mn_r}) - $signed({1'b0, mx_l});
    ov_h   = $signed({1'b0, mn_d}) - $signed({1'b0, mx_t});
    rd_sc  = sc_rdata[ScW-1:CLASS_BITS];
    rd_cls = sc_rdata[CLASS_BITS-1:0];
    s1_cand = !done_q[s1_idx_q] && (rd_cls == best_cls_q);
    s5_sup  = s5_pos_q && ($signed({4'b0, s5_inter_q, 16'b0}) > s5_prod_q);
  end

  assign pipe_busy = s1_v_q || s2_v_q || s3_v_q || s4_v_q || s5_v_q;
  assign scan_end  = (scan_q == cnt_q) && !pipe_busy;
  assign emit_go   = (state_q == StEmit) && (!ov_q || out_kept.ready);

  // Pipeline stage registers, payload only
  always_ff @(posedge clk_i) begin
    s1_idx_q   <= scan_q[IdxW-1:0];
    s2_idx_q   <= s1_idx_q;
    s2_c_q     <= s1_cand;
    s2_iw_q    <= ov_w[FieldW] ? '0 : ov_w[FieldW-1:0];
    s2_ih_q    <= ov_h[FieldW] ? '0 : ov_h[FieldW-1:0];
    s2_wa_q    <= $signed({1'b0, a_xr}) - $signed({1'b0, a_xl});
    s2_ha_q    <= $signed({1'b0, a_yb}) - $signed({1'b0, a_yt});
    s2_wb_q    <= $signed({1'b0, b_xr}) - $signed({1'b0, b_xl});
    s2_hb_q    <= $signed({1'b0, b_yb}) - $signed({1'b0, b_yt});
    s3_idx_q   <= s2_idx_q;
    s3_c_q     <= s2_c_q;
    s3_inter_q <= s2_iw_q * s2_ih_q;
    s3_aa_q    <= (2*FieldW+2)'(s2_wa_q * s2_ha_q);
    s3_ab_q    <= (2*FieldW+2)'(s2_wb_q * s2_hb_q);
    s4_idx_q   <= s3_idx_q;
    s4_c_q     <= s3_c_q;
    s4_inter_q <= s3_inter_q;
    s4_uni_q   <= (2*FieldW+3)'(s3_aa_q) + (2*FieldW+3)'(s3_ab_q)
                  - $signed({3'b0, s3_inter_q});
    s5_idx_q   <= s4_idx_q;
    s5_c_q     <= s4_c_q;
    s5_inter_q <= s4_inter_q;
    s5_pos_q   <= (s4_uni_q > 0);
    s5_prod_q  <= (3*FieldW+4)'($signed({1'b0, thr_q}) * s4_uni_q);
  end

  // Sequencer, store count, suppression flags and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      thr_q      <= IouThrReset;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      scan_q     <= '0;
      done_q     <= '0;
      any_left_q <= 1'b0;
      found_q    <= 1'b0;
      best_idx_q <= '0;
      best_sc_q  <= '0;
      best_cls_q <= '0;
      best_cor_q <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      s4_v_q     <= 1'b0;
      s5_v_q     <= 1'b0;
      ov_q       <= 1'b0;
      out_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end

      // Advance the read pipeline
      s1_v_q <= issue;
      s2_v_q <= s1_v_q && (state_q == StSup);
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      if (issue) begin
        scan_q <= scan_q + 1'b1;
      end

      // Drop the output item once taken
      if (ov_q && out_kept.ready) begin
        ov_q <= 1'b0;
      end

      unique case (state_q)
        StLoad: begin
          if (in_box.valid) begin
            if (wr_en) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_box.data.last_box) begin
              state_q <= StSel;
              scan_q  <= '0;
              done_q  <= '0;
              found_q <= 1'b0;
            end
          end
        end
        StSel: begin
          // Track the best open box; ties keep the lower index
          if (s1_v_q && !done_q[s1_idx_q] && (!found_q || rd_sc > best_sc_q)) begin
            found_q    <= 1'b1;
            best_idx_q <= s1_idx_q;
            best_sc_q  <= rd_sc;
            best_cls_q <= rd_cls;
            best_cor_q <= cor_rdata;
          end
          if (scan_end) begin
            done_q[best_idx_q] <= 1'b1;
            scan_q     <= '0;
            any_left_q <= 1'b0;
            state_q    <= StSup;
          end
        end
        StSup: begin
          // Suppress overlapping boxes of the same class, note any box still open
          if (s5_v_q && s5_c_q && s5_sup) begin
            done_q[s5_idx_q] <= 1'b1;
          end
          if ((s5_v_q && s5_c_q && !s5_sup) ||
              (s1_v_q && !done_q[s1_idx_q] && (rd_cls != best_cls_q))) begin
            any_left_q <= 1'b1;
          end
          if (scan_end) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (emit_go) begin
            ov_q                <= 1'b1;
            out_q.kept_x_left   <= best_cor_q[FieldW-1:0];
            out_q.kept_y_top    <= best_cor_q[2*FieldW-1:FieldW];
            out_q.kept_x_right  <= best_cor_q[3*FieldW-1:2*FieldW];
            out_q.kept_y_bottom <= best_cor_q[4*FieldW-1:3*FieldW];
            out_q.kept_score    <= best_sc_q;
            out_q.kept_class    <= PortClassW'(best_cls_q);
            out_q.overflow      <= ovf_q;
            out_q.last_kept     <= !any_left_q;
            scan_q              <= '0;
            found_q             <= 1'b0;
            if (any_left_q) begin
              state_q <= StSel;
            end else begin
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= StLoad;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  assign out_kept.valid = ov_q;
  assign out_kept.data  = out_q;

endmodule

FILE: hw/rtl/pcnms_ram.sv
module pcnms_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/pcnms_checker.sv
module pcnms_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_last,
  input logic                 out_valid,
  input logic                 out_ready,
  input pcnms_pkg::box_out_t  out_data
);

  // A stalled kept item holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("kept item changed while stalled");

  // Closing a set stops intake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("intake open after last box");

  // Intake stays closed while a kept item other than the final one waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.last_kept |-> !in_ready)
    else $error("intake open before final kept item");

endmodule

bind per_class_greedy_nms_top pcnms_checker u_pcnms_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_box.valid),
  .in_ready (in_box.ready),
  .in_last  (in_box.data.last_box),
  .out_valid(out_kept.valid),
  .out_ready(out_kept.ready),
  .out_data (out_kept.data)
);
